FILE: src/assert_macros.svh
// ---------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion wrappers; empty when SYNTHESIS is defined.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS
`define ASSERT_PROP(label, clk, rst, prop) \
   label: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error("assertion failed");
`define ASSERT_NEVER(label, clk, rst, expr) \
   label: assert property (@(posedge clk) disable iff (rst) !(expr)) \
      else $error("forbidden condition seen");
`else
`define ASSERT_PROP(label, clk, rst, prop)
`define ASSERT_NEVER(label, clk, rst, expr)
`endif

`endif

FILE: src/fqkr_pkg.sv
// ---------------------------------------------------------------------------
// fqkr_pkg
// Sizes, operation codes and transaction types of the keyed-removal FIFO.
// ---------------------------------------------------------------------------
package fqkr_pkg;

   localparam int DEPTH      = 16;
   localparam int KEY_BITS   = 16;
   localparam int COUNT_BITS = 8;
   localparam int PTR_W      = $clog2(DEPTH);
   localparam int LVL_W      = $clog2(DEPTH + 1);

   localparam logic [1:0] FUNC_ENQ    = 2'd0;
   localparam logic [1:0] FUNC_DEQ    = 2'd1;
   localparam logic [1:0] FUNC_REMOVE = 2'd2;
   localparam logic [1:0] FUNC_SUB    = 2'd3;

   typedef logic [PTR_W-1:0] ptr_type;
   typedef logic [LVL_W-1:0] lvl_type;

   typedef struct packed {
      logic [1:0]            func;
      logic [KEY_BITS-1:0]   key;
      logic [COUNT_BITS-1:0] amount;
   } req_type;

   typedef struct packed {
      logic                  ok;
      logic [KEY_BITS-1:0]   head_key;
      logic [COUNT_BITS-1:0] head_count;
      lvl_type               occupancy;
      logic                  is_empty;
   } rsp_type;

   typedef struct packed {
      logic [KEY_BITS-1:0]   key;
      logic [COUNT_BITS-1:0] count;
   } entry_type;

   // base + off, wrapped into the ring
   function automatic ptr_type wrap_add(input ptr_type base, input ptr_type off);
      logic [PTR_W:0] s;
      s = {1'b0, base} + {1'b0, off};
      if (s >= (PTR_W + 1)'(DEPTH)) begin
         s = s - (PTR_W + 1)'(DEPTH);
      end
      return s[PTR_W-1:0];
   endfunction

endpackage

FILE: src/fifo_queue_with_keyed_removal.sv
// ---------------------------------------------------------------------------
// fifo_queue_with_keyed_removal
// Bounded FIFO of key/count entries with enqueue, dequeue, subtract from
// head, and removal of the first entry matching a key.
//
// Usage:
//   req_valid/req_ready/req_data carry one operation (func, key, amount).
//   rsp_valid/rsp_ready/rsp_data return one transaction per operation: ok,
//   head key and count, occupancy and empty flag after the operation.
//   Entries sit in a 16-entry ring buffer with one registered read port and
//   one write port; a small sequencer drives every access.
//   Sequencer steps from acceptance to rsp_valid:
//     enqueue, dequeue, any operation on an empty queue: head read and capture
//     subtract: write-back at the head, then head read and capture
//     remove: scan read and compare per entry scanned up to the match,
//     shift read and write per entry moved up behind it, head read, capture.
//   req_ready is high only while the sequencer is idle, so one operation is
//   in flight at a time. The result register lets the next request be taken
//   while a result waits; a stalled rsp_ready holds the sequencer at its
//   final step until the register frees up.
//   Reset empties the queue and drops any pending result; entry storage is
//   not cleared.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module fifo_queue_with_keyed_removal (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  fqkr_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output fqkr_pkg::rsp_type rsp_data
);
   import fqkr_pkg::*;

   localparam logic [2:0] ST_IDLE      = 3'd0;
   localparam logic [2:0] ST_SUB       = 3'd1;
   localparam logic [2:0] ST_SCAN_RD   = 3'd2;
   localparam logic [2:0] ST_SCAN_CMP  = 3'd3;
   localparam logic [2:0] ST_SHIFT_RD  = 3'd4;
   localparam logic [2:0] ST_SHIFT_WR  = 3'd5;
   localparam logic [2:0] ST_HEAD_RD   = 3'd6;
   localparam logic [2:0] ST_HEAD_CAP  = 3'd7;

   logic [2:0] state_ff, state_in;
   ptr_type    head_ff, head_in;
   lvl_type    fill_ff, fill_in;
   ptr_type    idx_ff, idx_in;
   req_type    op_ff, op_in;
   logic       ok_ff, ok_in;
   rsp_type    rsp_ff, rsp_in;
   logic       rsp_valid_ff, rsp_valid_in;

   entry_type  mem_ff [DEPTH];
   entry_type  rd_data_ff;
   ptr_type    rd_addr;
   logic       wr_en;
   ptr_type    wr_addr;
   entry_type  wr_data;

   logic       req_fire;
   lvl_type    idx_p1;
   lvl_type    idx_p2;

   assign req_ready = (state_ff == ST_IDLE);
   assign req_fire  = req_valid && req_ready;
   assign idx_p1    = LVL_W'(idx_ff) + LVL_W'(1);
   assign idx_p2    = LVL_W'(idx_ff) + LVL_W'(2);

   always_comb begin
      state_in     = state_ff;
      head_in      = head_ff;
      fill_in      = fill_ff;
      idx_in       = idx_ff;
      op_in        = op_ff;
      ok_in        = ok_ff;
      rsp_in       = rsp_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rd_addr      = head_ff;
      wr_en        = 1'b0;
      wr_addr      = head_ff;
      wr_data      = rd_data_ff;

      case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               op_in    = req_data;
               ok_in    = 1'b0;
               idx_in   = '0;
               state_in = ST_HEAD_RD;
               case (req_data.func)
                  FUNC_ENQ: begin
                     if (fill_ff < LVL_W'(DEPTH)) begin
                        wr_en         = 1'b1;
                        wr_addr       = wrap_add(head_ff, PTR_W'(fill_ff));
                        wr_data.key   = req_data.key;
                        wr_data.count = req_data.amount;
                        fill_in       = fill_ff + LVL_W'(1);
                        ok_in         = 1'b1;
                     end
                  end
                  FUNC_DEQ: begin
                     if (fill_ff != '0) begin
                        head_in = wrap_add(head_ff, PTR_W'(1));
                        fill_in = fill_ff - LVL_W'(1);
                        ok_in   = 1'b1;
                     end
                  end
                  FUNC_REMOVE: begin
                     if (fill_ff != '0) begin
                        state_in = ST_SCAN_RD;
                     end
                  end
                  default: begin
                     if (fill_ff != '0) begin
                        state_in = ST_SUB;
                     end
                  end
               endcase
            end
         end
         ST_SUB: begin
            wr_en   = 1'b1;
            wr_addr = head_ff;
            if (op_ff.amount > rd_data_ff.count) begin
               wr_data.count = '0;
            end else begin
               wr_data.count = rd_data_ff.count - op_ff.amount;
               ok_in         = 1'b1;
            end
            state_in = ST_HEAD_RD;
         end
         ST_SCAN_RD: begin
            rd_addr  = wrap_add(head_ff, idx_ff);
            state_in = ST_SCAN_CMP;
         end
         ST_SCAN_CMP: begin
            if (rd_data_ff.key == op_ff.key) begin
               ok_in = 1'b1;
               if (idx_p1 < fill_ff) begin
                  state_in = ST_SHIFT_RD;
               end else begin
                  fill_in  = fill_ff - LVL_W'(1);
                  state_in = ST_HEAD_RD;
               end
            end else if (idx_p1 < fill_ff) begin
               idx_in   = idx_ff + PTR_W'(1);
               state_in = ST_SCAN_RD;
            end else begin
               state_in = ST_HEAD_RD;
            end
         end
         ST_SHIFT_RD: begin
            rd_addr  = wrap_add(head_ff, idx_ff + PTR_W'(1));
            state_in = ST_SHIFT_WR;
         end
         ST_SHIFT_WR: begin
            wr_en   = 1'b1;
            wr_addr = wrap_add(head_ff, idx_ff);
            wr_data = rd_data_ff;
            idx_in  = idx_ff + PTR_W'(1);
            if (idx_p2 < fill_ff) begin
               state_in = ST_SHIFT_RD;
            end else begin
               fill_in  = fill_ff - LVL_W'(1);
               state_in = ST_HEAD_RD;
            end
         end
         ST_HEAD_RD: begin
            rd_addr  = head_ff;
            state_in = ST_HEAD_CAP;
         end
         ST_HEAD_CAP: begin
            rd_addr = head_ff;
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_in.ok         = ok_ff;
               rsp_in.head_key   = (fill_ff != '0) ? rd_data_ff.key : '0;
               rsp_in.head_count = (fill_ff != '0) ? rd_data_ff.count : '0;
               rsp_in.occupancy  = fill_ff;
               rsp_in.is_empty   = (fill_ff == '0);
               rsp_valid_in      = 1'b1;
               state_in          = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         head_ff      <= '0;
         fill_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         head_ff      <= head_in;
         fill_ff      <= fill_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      idx_ff <= idx_in;
      op_ff  <= op_in;
      ok_ff  <= ok_in;
      rsp_ff <= rsp_in;
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   `ASSERT_NEVER(a_fill_bound, clock, reset, fill_ff > LVL_W'(DEPTH))
   `ASSERT_PROP(a_enq_grows, clock, reset,
      (req_fire && req_data.func == FUNC_ENQ && fill_ff < LVL_W'(DEPTH)) |=>
      (fill_ff == $past(fill_ff) + LVL_W'(1)))
   `ASSERT_PROP(a_rsp_from_cap, clock, reset,
      $rose(rsp_valid_ff) |-> $past(state_ff == ST_HEAD_CAP))
   `ASSERT_PROP(a_busy_fill_drop, clock, reset,
      (state_ff != ST_IDLE) |=> (fill_ff == $past(fill_ff) ||
      fill_ff == $past(fill_ff) - LVL_W'(1)))

endmodule
